>>> rtl/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types, codes and widths of the triangle depth rasterizer.
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    localparam int NVERT     = 3;
    localparam int COORD_W   = 12;
    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int DIM_W     = 12;   // active frame size, up to 4095
    localparam int SCOORD_W  = 13;   // signed compare space for coordinates
    localparam int EXT_W     = 13;   // triangle edge vector component
    localparam int DIFF_W    = 14;   // pixel minus vertex
    localparam int PROD_W    = 28;   // edge products and edge values
    localparam int SQ_W      = 24;   // one squared axis distance
    localparam int DIST_W    = 26;   // squared distance, with room for far marker

    localparam logic [DIST_W-1:0] FAR_AWAY = '1;

    localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RESET_DIM = 10'd512;

    typedef struct packed {
        logic [NVERT-1:0][COORD_W-1:0] vx;
        logic [NVERT-1:0][COORD_W-1:0] vy;
        logic [NVERT-1:0][DEPTH_W-1:0] vd;
        logic [NVERT-1:0]              mask;
    } t_tri;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VSEL,
        ST_VCMP,
        ST_BBOX,
        ST_ORIGIN,
        ST_SCAN,
        ST_DRAIN,
        ST_RD,
        ST_RDDATA,
        ST_DONE
    } t_state;

endpackage

>>> rtl/tdr_ram.sv
// ----------------------------------------------------------------------------
// tdr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tdr_shade.sv
// ----------------------------------------------------------------------------
// tdr_shade
// Pixel pipeline: edge test and nearest visible vertex, one pixel per cycle.
// ----------------------------------------------------------------------------
module tdr_shade #(
    parameter int MAX_WIDTH  = tdr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tdr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  tdr_pkg::t_tri                             i_tri,
    input  logic                                      i_occl,
    input  logic                                      i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]              i_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0]             i_y,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   i_addr,
    output logic                                      o_rd_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   o_rd_addr,
    input  logic [tdr_pkg::DEPTH_W-1:0]               i_rd_data,
    output logic                                      o_wr_en,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   o_wr_addr,
    output logic [tdr_pkg::DEPTH_W-1:0]               o_wr_data,
    output logic                                      o_busy
);

    localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int DW = tdr_pkg::DIFF_W;
    localparam int PW = tdr_pkg::PROD_W;
    localparam int NV = tdr_pkg::NVERT;

    // triangle edge vectors, steady during a scan
    logic signed [tdr_pkg::EXT_W-1:0] r_ex [NV];
    logic signed [tdr_pkg::EXT_W-1:0] r_ey [NV];

    // stage 1: offsets from each vertex
    logic                 r_v1;
    logic [AW-1:0]        r_a1;
    logic signed [DW-1:0] r_dx [NV];
    logic signed [DW-1:0] r_dy [NV];
    logic signed [DW-1:0] xs, ys;
    logic signed [DW-1:0] n_dx [NV];
    logic signed [DW-1:0] n_dy [NV];

    // stage 2: products, old pixel arrives from memory
    logic                            r_v2;
    logic [AW-1:0]                   r_a2;
    logic signed [PW-1:0]            r_p [NV];
    logic signed [PW-1:0]            r_q [NV];
    logic [tdr_pkg::SQ_W-1:0]        r_sx [NV];
    logic [tdr_pkg::SQ_W-1:0]        r_sy [NV];
    logic signed [PW-1:0]            n_p [NV];
    logic signed [PW-1:0]            n_q [NV];
    logic signed [PW-1:0]            n_sx [NV];
    logic signed [PW-1:0]            n_sy [NV];

    // stage 3: edge values and distances, decide and write
    logic                            r_v3;
    logic [AW-1:0]                   r_a3;
    logic signed [PW-1:0]            r_e [NV];
    logic [tdr_pkg::DIST_W-1:0]      r_d [NV];
    logic [tdr_pkg::DEPTH_W-1:0]     r_old;

    logic in_tri;
    logic [tdr_pkg::DEPTH_W-1:0] pick;

    assign xs = DW'(i_x);
    assign ys = DW'(i_y);

    always_comb begin
        for (int k = 0; k < NV; k++) begin
            n_dx[k] = xs - DW'($signed(i_tri.vx[k]));
            n_dy[k] = ys - DW'($signed(i_tri.vy[k]));
            n_p[k]  = PW'(r_ex[k]) * PW'(r_dy[k]);
            n_q[k]  = PW'(r_ey[k]) * PW'(r_dx[k]);
            n_sx[k] = PW'(r_dx[k]) * PW'(r_dx[k]);
            n_sy[k] = PW'(r_dy[k]) * PW'(r_dy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NV; k++) begin
            r_ex[k] <= tdr_pkg::EXT_W'($signed(i_tri.vx[(k == NV-1) ? 0 : k+1]))
                     - tdr_pkg::EXT_W'($signed(i_tri.vx[k]));
            r_ey[k] <= tdr_pkg::EXT_W'($signed(i_tri.vy[(k == NV-1) ? 0 : k+1]))
                     - tdr_pkg::EXT_W'($signed(i_tri.vy[k]));
            r_dx[k] <= n_dx[k];
            r_dy[k] <= n_dy[k];
            r_p[k]  <= n_p[k];
            r_q[k]  <= n_q[k];
            r_sx[k] <= tdr_pkg::SQ_W'(n_sx[k]);
            r_sy[k] <= tdr_pkg::SQ_W'(n_sy[k]);
            r_e[k]  <= r_p[k] - r_q[k];
            r_d[k]  <= i_tri.mask[k]
                     ? tdr_pkg::DIST_W'(r_sx[k]) + tdr_pkg::DIST_W'(r_sy[k])
                     : tdr_pkg::FAR_AWAY;
        end
        r_a1  <= i_addr;
        r_a2  <= r_a1;
        r_a3  <= r_a2;
        r_old <= i_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // edges count as inside, either winding
    always_comb begin
        in_tri = (!r_e[0][PW-1] && !r_e[1][PW-1] && !r_e[2][PW-1])
              || ((r_e[0][PW-1] || r_e[0] == '0)
               && (r_e[1][PW-1] || r_e[1] == '0)
               && (r_e[2][PW-1] || r_e[2] == '0));
        if (r_d[0] < r_d[1]) begin
            pick = (r_d[0] < r_d[2]) ? i_tri.vd[0] : i_tri.vd[2];
        end else begin
            pick = (r_d[1] < r_d[2]) ? i_tri.vd[1] : i_tri.vd[2];
        end
    end

    assign o_rd_en   = r_v1;
    assign o_rd_addr = r_a1;
    assign o_wr_en   = r_v3 && in_tri && !(i_occl && r_old != '0);
    assign o_wr_addr = r_a3;
    assign o_wr_data = pick;
    assign o_busy    = r_v1 || r_v2 || r_v3;

endmodule

>>> rtl/triangle_depth_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer
// Depth frame with triangle draw, pixel read and frame clear.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  s        in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (op)
//  m        out  o_m_tvalid / i_m_tready   o_m_tdata
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Clear writes one word per cycle. Draw reads and compares each in-frame visible
// vertex, passes over the other vertices, then clips the bounding box to the frame
// and scans it, 1 px/cycle; an empty box or no visible vertex skips the scan.
// After reset a clearing pass over the whole store holds o_s_tready low.
// Configuration writes are always taken (o_cfg_ready = 1).
// A stalled output holds its transaction; a new item may still be accepted.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer #(
    parameter int MAX_WIDTH  = tdr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tdr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // v1x, v1y, v2x, v2y, v3x, v3y, d1, d2, d3, visible_mask, zero pad
    input  logic [127:0]                    i_s_tdata,
    // op
    input  logic [tdr_pkg::OP_W-1:0]        i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pixel_depth, occluded, zero pad
    output logic [23:0]                     o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tdr_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int FRAME = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(FRAME);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CW    = tdr_pkg::COORD_W;
    localparam int DPW   = tdr_pkg::DEPTH_W;
    localparam int SW    = tdr_pkg::SCOORD_W;
    localparam int NW    = tdr_pkg::DIM_W;

    tdr_pkg::t_state r_state, n_state;
    tdr_pkg::t_tri   r_tri;

    logic [tdr_pkg::CFG_W-1:0] r_width, r_height;
    logic [NW-1:0]             act_w, act_h;

    logic [1:0]     r_vi;          // vertex under test, 3 means done
    logic [AW-1:0]  r_vaddr;
    logic [DPW-1:0] r_vdep;
    logic           r_occl;
    logic           r_clr_op;
    logic [AW-1:0]  r_caddr;
    logic           r_rd_ok;
    logic [DPW-1:0] r_res_depth;

    // bounding box and scan position
    logic [XW-1:0]  r_x0, r_x1, r_x;
    logic [YW-1:0]  r_y0, r_y1, r_y;
    logic           r_empty;
    logic [AW-1:0]  r_row, r_addr;

    // output register
    logic           r_ovalid;
    logic [DPW-1:0] r_o_depth;
    logic           r_o_occl;

    // memory ports
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [DPW-1:0] ram_wdata, ram_rdata;

    // pixel pipeline
    logic           sh_valid, sh_rd_en, sh_wr_en, sh_busy;
    logic [AW-1:0]  sh_rd_addr, sh_wr_addr;
    logic [DPW-1:0] sh_wr_data;

    logic           s_acc, m_load, scan_last_x, scan_last_y;
    logic [CW-1:0]  sel_x, sel_y;
    logic [DPW-1:0] sel_d;
    logic           sel_vis, sel_in, rd_in;
    logic [AW-1:0]  sel_addr, rd_addr;
    logic [SW-1:0]  bx0, bx1, by0, by1;
    logic           box_empty;

    function automatic logic in_frame(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                      input logic [NW-1:0] w, input logic [NW-1:0] h);
        in_frame = !x[CW-1] && !y[CW-1] && (NW'(x) < w) && (NW'(y) < h);
    endfunction

    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
        pix_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        smin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        smax = (a > b) ? a : b;
    endfunction

    // registers above the store size act as the store size
    assign act_w = (NW'(r_width) > NW'(MAX_WIDTH)) ? NW'(MAX_WIDTH) : NW'(r_width);
    assign act_h = (NW'(r_height) > NW'(MAX_HEIGHT)) ? NW'(MAX_HEIGHT) : NW'(r_height);

    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_load      = (r_state == tdr_pkg::ST_DONE) && (!r_ovalid || i_m_tready);

    // vertex under test
    always_comb begin
        sel_x   = r_tri.vx[0];
        sel_y   = r_tri.vy[0];
        sel_d   = r_tri.vd[0];
        sel_vis = r_tri.mask[0];
        case (r_vi)
            2'd1: begin
                sel_x   = r_tri.vx[1];
                sel_y   = r_tri.vy[1];
                sel_d   = r_tri.vd[1];
                sel_vis = r_tri.mask[1];
            end
            2'd2: begin
                sel_x   = r_tri.vx[2];
                sel_y   = r_tri.vy[2];
                sel_d   = r_tri.vd[2];
                sel_vis = r_tri.mask[2];
            end
            default: begin
            end
        endcase
    end

    assign sel_in   = sel_vis && (r_vi != 2'd3)
                   && in_frame(sel_x, sel_y, act_w, act_h);
    assign sel_addr = pix_addr(sel_x, sel_y);
    assign rd_in    = in_frame(r_tri.vx[0], r_tri.vy[0], act_w, act_h);
    assign rd_addr  = pix_addr(r_tri.vx[0], r_tri.vy[0]);

    // bounding box clipped to the active frame
    always_comb begin
        logic signed [SW-1:0] sx0, sx1, sx2, sy0, sy1, sy2, wm1, hm1;
        sx0 = SW'($signed(r_tri.vx[0]));
        sx1 = SW'($signed(r_tri.vx[1]));
        sx2 = SW'($signed(r_tri.vx[2]));
        sy0 = SW'($signed(r_tri.vy[0]));
        sy1 = SW'($signed(r_tri.vy[1]));
        sy2 = SW'($signed(r_tri.vy[2]));
        wm1 = $signed({1'b0, act_w}) - SW'(1);
        hm1 = $signed({1'b0, act_h}) - SW'(1);
        bx0 = smax(smin(smin(sx0, sx1), sx2), '0);
        by0 = smax(smin(smin(sy0, sy1), sy2), '0);
        bx1 = smin(smax(smax(sx0, sx1), sx2), wm1);
        by1 = smin(smax(smax(sy0, sy1), sy2), hm1);
        box_empty = ($signed(bx0) > $signed(bx1)) || ($signed(by0) > $signed(by1));
    end

    assign scan_last_x = (r_x == r_x1);
    assign scan_last_y = (r_y == r_y1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdr_pkg::ST_CLEAR: begin
                if (r_caddr == AW'(FRAME - 1)) begin
                    n_state = r_clr_op ? tdr_pkg::ST_DONE : tdr_pkg::ST_IDLE;
                end
            end
            tdr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        tdr_pkg::OP_DRAW: begin
                            n_state = (i_s_tdata[122:120] != '0) ? tdr_pkg::ST_VSEL
                                                                 : tdr_pkg::ST_DONE;
                        end
                        tdr_pkg::OP_READ:  n_state = tdr_pkg::ST_RD;
                        tdr_pkg::OP_CLEAR: n_state = tdr_pkg::ST_CLEAR;
                        default:           n_state = tdr_pkg::ST_DONE;
                    endcase
                end
            end
            tdr_pkg::ST_VSEL: begin
                if (r_vi == 2'd3) begin
                    n_state = tdr_pkg::ST_BBOX;
                end else if (sel_in) begin
                    n_state = tdr_pkg::ST_VCMP;
                end
            end
            tdr_pkg::ST_VCMP:   n_state = tdr_pkg::ST_VSEL;
            tdr_pkg::ST_BBOX:   n_state = box_empty ? tdr_pkg::ST_DONE : tdr_pkg::ST_ORIGIN;
            tdr_pkg::ST_ORIGIN: n_state = tdr_pkg::ST_SCAN;
            tdr_pkg::ST_SCAN: begin
                if (scan_last_x && scan_last_y) begin
                    n_state = tdr_pkg::ST_DRAIN;
                end
            end
            tdr_pkg::ST_DRAIN: begin
                if (!sh_busy) begin
                    n_state = tdr_pkg::ST_DONE;
                end
            end
            tdr_pkg::ST_RD:     n_state = tdr_pkg::ST_RDDATA;
            tdr_pkg::ST_RDDATA: n_state = tdr_pkg::ST_DONE;
            tdr_pkg::ST_DONE: begin
                if (m_load) begin
                    n_state = tdr_pkg::ST_IDLE;
                end
            end
            default: n_state = tdr_pkg::ST_IDLE;
        endcase
    end

    // memory port control and handshake outputs
    always_comb begin
        o_s_tready = (r_state == tdr_pkg::ST_IDLE);
        sh_valid   = (r_state == tdr_pkg::ST_SCAN);
        ram_we     = 1'b0;
        ram_waddr  = sh_wr_addr;
        ram_wdata  = sh_wr_data;
        ram_re     = sh_rd_en;
        ram_raddr  = sh_rd_addr;
        case (r_state)
            tdr_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_caddr;
                ram_wdata = '0;
            end
            tdr_pkg::ST_VSEL: begin
                ram_re    = sel_in;
                ram_raddr = sel_addr;
            end
            tdr_pkg::ST_VCMP: begin
                // empty pixel or not farther: the vertex wins
                ram_we    = (ram_rdata == '0) || (r_vdep <= ram_rdata);
                ram_waddr = r_vaddr;
                ram_wdata = r_vdep;
            end
            tdr_pkg::ST_SCAN, tdr_pkg::ST_DRAIN: begin
                ram_we = sh_wr_en;
            end
            tdr_pkg::ST_RD: begin
                ram_re    = rd_in;
                ram_raddr = rd_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tdr_pkg::ST_CLEAR;
            r_caddr  <= '0;
            r_clr_op <= 1'b0;
            r_ovalid <= 1'b0;
            r_width  <= tdr_pkg::CFG_RESET_DIM;
            r_height <= tdr_pkg::CFG_RESET_DIM;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tdr_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    tdr_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == tdr_pkg::ST_CLEAR) begin
                r_caddr <= r_caddr + AW'(1);
            end
            if (s_acc) begin
                r_caddr  <= '0;
                r_clr_op <= (i_s_tuser == tdr_pkg::OP_CLEAR);
            end
            if (m_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int k = 0; k < tdr_pkg::NVERT; k++) begin
                r_tri.vx[k] <= i_s_tdata[24*k +: CW];
                r_tri.vy[k] <= i_s_tdata[24*k + CW +: CW];
                r_tri.vd[k] <= i_s_tdata[72 + DPW*k +: DPW];
            end
            r_tri.mask  <= i_s_tdata[122:120];
            r_vi        <= '0;
            r_occl      <= 1'b0;
            r_res_depth <= '0;
        end
        case (r_state)
            tdr_pkg::ST_VSEL: begin
                r_vaddr <= sel_addr;
                r_vdep  <= sel_d;
                if (r_vi != 2'd3 && !sel_in) begin
                    r_vi <= r_vi + 2'd1;
                end
            end
            tdr_pkg::ST_VCMP: begin
                if (!((ram_rdata == '0) || (r_vdep <= ram_rdata))) begin
                    r_occl <= 1'b1;
                end
                r_vi <= r_vi + 2'd1;
            end
            tdr_pkg::ST_BBOX: begin
                r_x0    <= XW'(bx0);
                r_x1    <= XW'(bx1);
                r_y0    <= YW'(by0);
                r_y1    <= YW'(by1);
                r_empty <= box_empty;
            end
            tdr_pkg::ST_ORIGIN: begin
                r_x    <= r_x0;
                r_y    <= r_y0;
                r_row  <= AW'(r_y0) * AW'(MAX_WIDTH);
                r_addr <= AW'(r_y0) * AW'(MAX_WIDTH) + AW'(r_x0);
            end
            tdr_pkg::ST_SCAN: begin
                if (scan_last_x) begin
                    r_x    <= r_x0;
                    r_y    <= r_y + YW'(1);
                    r_row  <= r_row + AW'(MAX_WIDTH);
                    r_addr <= r_row + AW'(MAX_WIDTH) + AW'(r_x0);
                end else begin
                    r_x    <= r_x + XW'(1);
                    r_addr <= r_addr + AW'(1);
                end
            end
            tdr_pkg::ST_RD: begin
                r_rd_ok <= rd_in;
            end
            tdr_pkg::ST_RDDATA: begin
                r_res_depth <= r_rd_ok ? ram_rdata : '0;
            end
            default: begin
            end
        endcase
        if (m_load) begin
            r_o_depth <= r_res_depth;
            r_o_occl  <= r_occl && !r_empty ? r_occl : r_occl;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0, r_o_occl, r_o_depth};

    tdr_ram #(
        .WIDTH (DPW),
        .DEPTH (FRAME)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tdr_shade #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_shade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tri     (r_tri),
        .i_occl    (r_occl),
        .i_valid   (sh_valid),
        .i_x       (r_x),
        .i_y       (r_y),
        .i_addr    (r_addr),
        .o_rd_en   (sh_rd_en),
        .o_rd_addr (sh_rd_addr),
        .i_rd_data (ram_rdata),
        .o_wr_en   (sh_wr_en),
        .o_wr_addr (sh_wr_addr),
        .o_wr_data (sh_wr_data),
        .o_busy    (sh_busy)
    );

endmodule

>>> rtl/tdr_checker.sv
// ----------------------------------------------------------------------------
// tdr_checker
// Port-level checks of the triangle depth rasterizer.
// ----------------------------------------------------------------------------
module tdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // reset starts the clearing pass and empties the output
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_s_tready && !o_m_tvalid))
        else $error("input open or output valid right after reset");

    // one operation at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transaction taken back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

endmodule

bind triangle_depth_rasterizer tdr_checker u_tdr_checker (.*);
